// File: hw/rtl/tce_pkg.sv
// Shared types, widths and helpers for the transitive closure engine.
package tce_pkg;

  localparam int ROW_W            = 16;  // bits per adjacency row
  localparam int IDX_W            = 4;   // width of an emitted row index
  localparam int CNT_W            = 5;   // width of vertex count and row counters
  localparam int MAX_VERTICES_DEF = 16;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_CLOSE = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  // Emit request from the sequencer to the merge stage
  typedef struct packed {
    logic             go;
    logic [IDX_W-1:0] index;
    logic             last;
  } emit_ctl_t;

  // Mask of the low n bits of a row (n = ROW_W gives all ones)
  function automatic row_t size_mask(input cnt_t n);
    logic [ROW_W:0] wide;
    wide = ({{ROW_W{1'b0}}, 1'b1} << n) - {{ROW_W{1'b0}}, 1'b1};
    return wide[ROW_W-1:0];
  endfunction

endpackage

// File: hw/rtl/tce_lane.sv
// One row lane: holds a matrix row and applies the pivot OR during a pass.
module tce_lane (
  input  logic                     clk,
  input  logic                     load_en,
  input  tce_pkg::row_t            load_row,
  input  logic                     close_en,
  input  logic [tce_pkg::IDX_W-1:0] pivot_idx,
  input  tce_pkg::row_t            pivot_row,
  output tce_pkg::row_t            row_o
);
  import tce_pkg::*;

  row_t row_r;
  row_t row_nxt;

  // Load a fresh row, or OR in the pivot row when this row reaches pivot k
  always_comb begin
    row_nxt = row_r;
    if (load_en) begin
      row_nxt = load_row;
    end else if (close_en && row_r[pivot_idx]) begin
      row_nxt = row_r | pivot_row;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  assign row_o = row_r;

endmodule

// File: hw/rtl/tce_merge.sv
// Merge stage: selects one lane row (pivot or result) and holds the output register.
module tce_merge #(
  parameter int Rows = tce_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tce_pkg::row_t             rows_i [Rows],
  input  logic [$clog2(Rows)-1:0]   rd_addr,
  input  tce_pkg::emit_ctl_t        ctl,
  input  logic                      out_stall,
  output tce_pkg::row_t             sel_row,
  output logic                      out_valid,
  output logic [tce_pkg::IDX_W-1:0] out_row_index,
  output tce_pkg::row_t             out_result_row,
  output logic                      out_last
);
  import tce_pkg::*;

  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] index_r;
  row_t             row_r;
  logic             last_r;

  // Shared read port over the lanes
  assign sel_row = rows_i[rd_addr];

  // Valid holds while stalled, set on every new emit
  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (ctl.go) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      index_r <= ctl.index;
      row_r   <= sel_row;
      last_r  <= ctl.last;
    end
  end

  assign out_valid      = valid_r;
  assign out_row_index  = index_r;
  assign out_result_row = row_r;
  assign out_last       = last_r;

endmodule

// File: hw/rtl/transitive_closure_engine.sv
// Top level of the transitive closure engine: sequencer, row lanes and merge stage.
//
//  channel | ports                                         | dir | handshake
//  --------+-----------------------------------------------+-----+----------------------
//  cfg     | cfg_write_en, cfg_vertex_count                | in  | write on enable
//  in      | in_valid, in_stall, in_row_bits               | in  | valid & !stall
//  out     | out_valid, out_stall, out_row_index,          | out | valid & !stall
//          | out_result_row, out_last                      |     |
//
// A matrix of n rows is loaded one row per accepted request, closed by n pivot
// passes (all row lanes in parallel) and then emitted one result row at a time.
// Input is stalled from the last row of a matrix until its last result row is
// in the output register. Reset clears the sequencer and row count, not the rows.
// A stalled output holds its request; emission waits for the register to free.
module transitive_closure_engine #(
  parameter int MAX_VERTICES = tce_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_write_en,
  input  tce_pkg::cnt_t             cfg_vertex_count,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tce_pkg::row_t             in_row_bits,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tce_pkg::IDX_W-1:0] out_row_index,
  output tce_pkg::row_t             out_result_row,
  output logic                      out_last
);
  import tce_pkg::*;

  localparam int Rows = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int AW   = $clog2(Rows);

  state_t    state_r, state_nxt;
  cnt_t      vcount_r, vcount_nxt;
  cnt_t      loaded_r, loaded_nxt;
  cnt_t      step_r, step_nxt;
  cnt_t      n_eff;
  cnt_t      n_m1;
  row_t      load_row;
  row_t      pivot_row;
  row_t      lane_rows [Rows];
  logic      in_acc;
  logic      close_en;
  logic      out_free;
  emit_ctl_t emit_ctl;

  // Effective vertex count and masked load row
  assign n_eff    = (vcount_r > CNT_W'(Rows)) ? CNT_W'(Rows) : vcount_r;
  assign n_m1     = n_eff - CNT_W'(1);
  assign load_row = in_row_bits & size_mask(n_eff);

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign close_en = (state_r == ST_CLOSE);
  assign out_free = !out_valid || !out_stall;

  // Emit request towards the merge stage
  always_comb begin
    emit_ctl.go    = (state_r == ST_EMIT) && out_free;
    emit_ctl.index = step_r[IDX_W-1:0];
    emit_ctl.last  = (step_r == n_m1);
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    vcount_nxt = vcount_r;
    loaded_nxt = loaded_r;
    step_nxt   = step_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && (n_eff != '0)) begin
          if (loaded_r == n_m1) begin
            loaded_nxt = '0;
            step_nxt   = '0;
            state_nxt  = ST_CLOSE;
          end else begin
            loaded_nxt = loaded_r + CNT_W'(1);
          end
        end
      end
      ST_CLOSE: begin
        if (step_r == n_m1) begin
          step_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (emit_ctl.go) begin
          if (emit_ctl.last) begin
            step_nxt  = '0;
            state_nxt = ST_LOAD;
          end else begin
            step_nxt = step_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    // Config write sets the vertex count and restarts the load row count
    if (cfg_write_en) begin
      vcount_nxt = cfg_vertex_count;
      loaded_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      vcount_r <= '0;
      loaded_r <= '0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      vcount_r <= vcount_nxt;
      loaded_r <= loaded_nxt;
      step_r   <= step_nxt;
    end
  end

  // Row lanes
  for (genvar i = 0; i < Rows; i++) begin : g_lane
    tce_lane u_lane (
      .clk       (clk),
      .load_en   (in_acc && (n_eff != '0) && (loaded_r == CNT_W'(i))),
      .load_row  (load_row),
      .close_en  (close_en),
      .pivot_idx (step_r[IDX_W-1:0]),
      .pivot_row (pivot_row),
      .row_o     (lane_rows[i])
    );
  end

  // Merge stage: pivot read during passes, result read during emission
  tce_merge #(
    .Rows (Rows)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .rows_i         (lane_rows),
    .rd_addr        (step_r[AW-1:0]),
    .ctl            (emit_ctl),
    .out_stall      (out_stall),
    .sel_row        (pivot_row),
    .out_valid      (out_valid),
    .out_row_index  (out_row_index),
    .out_result_row (out_result_row),
    .out_last       (out_last)
  );

endmodule

// File: hw/rtl/tce_checker.sv
// Port-level checks for the transitive closure engine, bound to the top level.
module tce_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [tce_pkg::IDX_W-1:0] out_row_index,
  input tce_pkg::row_t             out_result_row,
  input logic                      out_last
);
  import tce_pkg::*;

  // A stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_row_index)
      && $stable(out_result_row) && $stable(out_last)))
    else $error("stalled result request changed");

  // Input is held off while a matrix still has rows to emit
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !(in_valid && !in_stall))
    else $error("input accepted during emission");

  // Rows of one matrix follow back to back in index order
  a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && (out_row_index == $past(out_row_index) + 4'd1)))
    else $error("result rows out of order or gapped");

  // A matrix starts at row zero
  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_row_index == '0))
    else $error("matrix does not start at row zero");

endmodule

bind transitive_closure_engine tce_checker u_tce_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_row_index  (out_row_index),
  .out_result_row (out_result_row),
  .out_last       (out_last)
);
